[rtl/core/round_robin_quantum_scheduler_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the round robin quantum scheduler core
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define RRQS_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("rrqs assertion failed");

// next-cycle implication
`define RRQS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("rrqs assertion failed");

`endif

[rtl/core/rrqs_pkg.sv]
// ---------------------------------------------------------------------------
// rrqs_pkg
// Types, codes and sizes shared by the round robin quantum scheduler.
// ---------------------------------------------------------------------------
package rrqs_pkg;

  localparam int SLOTS      = 16;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int TIME_W     = 16;
  localparam int KIND_W     = 3;
  localparam int SLOT_FW    = 4;
  localparam int BURST_W    = 4;
  localparam int IO_W       = 3;
  localparam int TQ_W       = 4;
  localparam int PC_W       = 5;
  localparam int DONE_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [TIME_W-1:0] TMAX     = {TIME_W{1'b1}};
  localparam logic [DONE_W-1:0] DONE_MAX = {DONE_W{1'b1}};
  localparam logic [TQ_W-1:0]   TQ_RESET = TQ_W'(3);
  localparam logic [PC_W-1:0]   PC_RESET = PC_W'(10);

  localparam logic [KIND_W-1:0] KIND_CREATE = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_TICK   = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_IO     = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_EXIT   = KIND_W'(3);
  localparam logic [KIND_W-1:0] KIND_START  = KIND_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_TQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PC = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_READY = 2'd0,
    ST_RUN   = 2'd1,
    ST_SLEEP = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_TICK   = 3'd1,
    OP_IO     = 3'd2,
    OP_EXIT   = 3'd3,
    OP_START  = 3'd4,
    OP_NOP    = 3'd5
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic               inr;
    logic [BURST_W-1:0] burst;
    logic [IO_W-1:0]    io;
    logic               eni;
  } event_t;

  typedef struct packed {
    logic [TQ_W-1:0]  tq;
    logic [PC_W-1:0]  pc;
    logic [CNT_W-1:0] n;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    logic [TQ_W-1:0]    q;
    logic [BURST_W-1:0] b;
    logic [IO_W-1:0]    s;
    logic [TIME_W-1:0]  rt;
    logic [TIME_W-1:0]  arr;
  } rec_t;

  typedef struct packed {
    logic               running_valid;
    logic [SLOT_FW-1:0] running_slot;
    logic               dispatched;
    logic               end_request;
    logic               finished_valid;
    logic [TIME_W-1:0]  finished_wait;
    logic [TIME_W-1:0]  finished_turnaround;
    logic [DONE_W-1:0]  finished_count;
    logic               all_done;
    logic [TIME_W-1:0]  now;
  } result_t;

endpackage

[rtl/core/rrqs_ifs.sv]
// ---------------------------------------------------------------------------
// rrqs channel interfaces
// Event, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface rrqs_evt_if;
  logic                         valid;
  logic                         ready;
  logic [rrqs_pkg::KIND_W-1:0]  kind;
  logic [rrqs_pkg::SLOT_FW-1:0] slot;
  logic [rrqs_pkg::BURST_W-1:0] burst;
  logic [rrqs_pkg::IO_W-1:0]    io_time;
  logic                         end_not_io;
  modport source (output valid, kind, slot, burst, io_time, end_not_io, input ready);
  modport sink (input valid, kind, slot, burst, io_time, end_not_io, output ready);
endinterface

interface rrqs_res_if;
  logic                         valid;
  logic                         ready;
  logic                         running_valid;
  logic [rrqs_pkg::SLOT_FW-1:0] running_slot;
  logic                         dispatched;
  logic                         end_request;
  logic                         finished_valid;
  logic [rrqs_pkg::TIME_W-1:0]  finished_wait;
  logic [rrqs_pkg::TIME_W-1:0]  finished_turnaround;
  logic [rrqs_pkg::DONE_W-1:0]  finished_count;
  logic                         all_done;
  logic [rrqs_pkg::TIME_W-1:0]  now;
  modport source (output valid, running_valid, running_slot, dispatched, end_request,
                  finished_valid, finished_wait, finished_turnaround, finished_count,
                  all_done, now, input ready);
  modport sink (input valid, running_valid, running_slot, dispatched, end_request,
                finished_valid, finished_wait, finished_turnaround, finished_count,
                all_done, now, output ready);
endinterface

interface rrqs_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrqs_pkg::CFG_IDX_W-1:0]  index;
  logic [rrqs_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/rrqs_front.sv]
// ---------------------------------------------------------------------------
// rrqs_front
// Accepts event transactions, decodes them and holds the configuration.
// ---------------------------------------------------------------------------
module rrqs_front (
  input  logic              clk,
  input  logic              rst,
  rrqs_evt_if.sink          evt,
  rrqs_cfg_if.sink          cfg,
  input  logic              full,
  output logic              push,
  output rrqs_pkg::event_t  push_data,
  output rrqs_pkg::cfg_t    cfg_o
);

  logic [rrqs_pkg::TQ_W-1:0] tq;
  logic [rrqs_pkg::PC_W-1:0] pc;
  logic [rrqs_pkg::CNT_W-1:0] n;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tq <= rrqs_pkg::TQ_RESET;
      pc <= rrqs_pkg::PC_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        rrqs_pkg::REG_TQ: tq <= cfg.data[rrqs_pkg::TQ_W-1:0];
        rrqs_pkg::REG_PC: pc <= cfg.data[rrqs_pkg::PC_W-1:0];
        default: ;
      endcase
    end
  end

  assign n = ({1'b0, pc} < (rrqs_pkg::PC_W + 1)'(rrqs_pkg::SLOTS)) ?
             rrqs_pkg::CNT_W'(pc) : rrqs_pkg::CNT_W'(rrqs_pkg::SLOTS);

  assign cfg_o.tq = tq;
  assign cfg_o.pc = pc;
  assign cfg_o.n  = n;

  assign evt.ready = !full;
  assign push      = evt.valid && !full;

  always_comb begin
    push_data.slot  = rrqs_pkg::SLOT_W'(evt.slot);
    push_data.inr   = rrqs_pkg::CNT_W'(evt.slot) < n;
    push_data.burst = evt.burst;
    push_data.io    = evt.io_time;
    push_data.eni   = evt.end_not_io;
    unique case (evt.kind)
      rrqs_pkg::KIND_CREATE: push_data.op = rrqs_pkg::OP_CREATE;
      rrqs_pkg::KIND_TICK:   push_data.op = rrqs_pkg::OP_TICK;
      rrqs_pkg::KIND_IO:     push_data.op = rrqs_pkg::OP_IO;
      rrqs_pkg::KIND_EXIT:   push_data.op = rrqs_pkg::OP_EXIT;
      rrqs_pkg::KIND_START:  push_data.op = rrqs_pkg::OP_START;
      default:               push_data.op = rrqs_pkg::OP_NOP;
    endcase
  end

endmodule

[rtl/core/rrqs_fifo.sv]
// ---------------------------------------------------------------------------
// rrqs_fifo
// Short event queue between the decoder and the executor.
// ---------------------------------------------------------------------------
module rrqs_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rrqs_pkg::event_t din,
  output logic             full,
  input  logic             pop,
  output rrqs_pkg::event_t dout,
  output logic             empty
);

  rrqs_pkg::event_t entries [rrqs_pkg::FIFO_DEPTH];
  logic [rrqs_pkg::FIFO_AW-1:0] wp;
  logic [rrqs_pkg::FIFO_AW-1:0] rp;
  logic [rrqs_pkg::FIFO_AW:0]   cnt;

  assign full  = cnt == (rrqs_pkg::FIFO_AW + 1)'(rrqs_pkg::FIFO_DEPTH);
  assign empty = cnt == '0;
  assign dout  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/rrqs_back.sv]
// ---------------------------------------------------------------------------
// rrqs_back
// Executes events over the slot table and drives the result register.
// ---------------------------------------------------------------------------
`include "round_robin_quantum_scheduler_core_macros.svh"

module rrqs_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             empty,
  input  rrqs_pkg::event_t head,
  output logic             pop,
  input  rrqs_pkg::cfg_t   cfg,
  rrqs_res_if.source       res
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_EXEC     = 16'h0002,
    S_WALK_RD  = 16'h0004,
    S_WALK_WR  = 16'h0008,
    S_RUN_RD   = 16'h0010,
    S_RUN_WR   = 16'h0020,
    S_EXIT_RD  = 16'h0040,
    S_EXIT_WR  = 16'h0080,
    S_DSTART   = 16'h0100,
    S_MOD      = 16'h0200,
    S_FIND_RD  = 16'h0400,
    S_FIND_CHK = 16'h0800,
    S_CUR_RD   = 16'h1000,
    S_CUR_CHK  = 16'h2000,
    S_CLAIM    = 16'h4000,
    S_OUT      = 16'h8000
  } state_t;

  state_t state;

  rrqs_pkg::rec_t mem [rrqs_pkg::SLOTS];
  logic [rrqs_pkg::SLOTS-1:0] vld;
  rrqs_pkg::rec_t rdata;
  logic           rvld;
  rrqs_pkg::rec_t rd;
  rrqs_pkg::status_t st;

  logic                        we;
  logic [rrqs_pkg::SLOT_W-1:0] waddr;
  logic [rrqs_pkg::SLOT_W-1:0] raddr;
  rrqs_pkg::rec_t              wdata;

  rrqs_pkg::event_t              ev;
  logic                          cur_valid;
  logic [rrqs_pkg::SLOT_W-1:0]   cur;
  logic                          last_valid;
  logic [rrqs_pkg::SLOT_W-1:0]   last;
  logic [rrqs_pkg::TIME_W-1:0]   tick;
  logic [rrqs_pkg::DONE_W-1:0]   done;
  logic [rrqs_pkg::SLOT_W-1:0]   ptr;
  logic [rrqs_pkg::CNT_W-1:0]    cnt;
  logic [rrqs_pkg::CNT_W-1:0]    start;
  logic                          found;
  rrqs_pkg::rec_t                hold;
  logic                          disp;
  logic                          endreq;
  logic                          fin;
  logic [rrqs_pkg::TIME_W-1:0]   fwait;
  logic [rrqs_pkg::TIME_W-1:0]   fturn;

  logic              res_valid;
  rrqs_pkg::result_t res_q;
  logic              out_free;

  logic [rrqs_pkg::BURST_W-1:0] b_dec;
  logic [rrqs_pkg::TQ_W-1:0]    q_dec;
  logic [rrqs_pkg::IO_W-1:0]    s_dec;
  logic                         last_step;
  logic [rrqs_pkg::SLOT_W-1:0]  ptr_wrap;

  assign st = rvld ? rdata.status : rrqs_pkg::ST_DONE;

  always_comb begin
    rd        = rdata;
    rd.status = st;
  end

  assign b_dec = (rd.b != '0) ? rd.b - 1'b1 : '0;
  assign q_dec = (rd.q != '0) ? rd.q - 1'b1 : '0;
  assign s_dec = (rd.s != '0) ? rd.s - 1'b1 : '0;
  assign last_step = (cnt + rrqs_pkg::CNT_W'(1)) == cfg.n;
  assign ptr_wrap  = ((rrqs_pkg::CNT_W'(ptr) + rrqs_pkg::CNT_W'(1)) == cfg.n) ?
                     '0 : ptr + 1'b1;
  assign out_free  = !res_valid || res.ready;
  assign pop       = (state == S_IDLE) && !empty;

  always_comb begin
    unique case (state)
      S_RUN_RD, S_CUR_RD: raddr = cur;
      S_EXIT_RD:          raddr = ev.slot;
      default:            raddr = ptr;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = rd;
    unique case (state)
      S_EXEC: begin
        if (ev.op == rrqs_pkg::OP_CREATE && ev.inr) begin
          we           = 1'b1;
          waddr        = ev.slot;
          wdata.status = rrqs_pkg::ST_READY;
          wdata.q      = cfg.tq;
          wdata.b      = ev.burst;
          wdata.s      = '0;
          wdata.rt     = '0;
          wdata.arr    = tick;
        end
      end
      S_WALK_WR: begin
        if (st == rrqs_pkg::ST_READY) begin
          we       = 1'b1;
          wdata.rt = (rd.rt != rrqs_pkg::TMAX) ? rd.rt + 1'b1 : rd.rt;
        end else if (st == rrqs_pkg::ST_SLEEP) begin
          we      = 1'b1;
          wdata.s = s_dec;
          if (s_dec == '0) begin
            wdata.status = rrqs_pkg::ST_READY;
            wdata.q      = cfg.tq;
          end
        end
      end
      S_RUN_WR: begin
        waddr = cur;
        if (st == rrqs_pkg::ST_RUN) begin
          we = 1'b1;
          if (ev.op == rrqs_pkg::OP_IO) begin
            wdata.status = rrqs_pkg::ST_SLEEP;
            wdata.s      = ev.io;
            wdata.b      = ev.burst;
          end else begin
            wdata.b = b_dec;
            wdata.q = q_dec;
            if (b_dec == '0) begin
              if (!ev.eni) begin
                wdata.status = rrqs_pkg::ST_SLEEP;
                wdata.s      = ev.io;
                wdata.b      = ev.burst;
              end
            end else if (q_dec == '0) begin
              wdata.status = rrqs_pkg::ST_READY;
              wdata.q      = cfg.tq;
            end
          end
        end
      end
      S_EXIT_WR: begin
        waddr = ev.slot;
        if (st != rrqs_pkg::ST_DONE) begin
          we           = 1'b1;
          wdata.status = rrqs_pkg::ST_DONE;
        end
      end
      S_CUR_CHK: begin
        waddr = cur;
        if (found && st == rrqs_pkg::ST_RUN) begin
          we           = 1'b1;
          wdata.status = rrqs_pkg::ST_READY;
        end
      end
      S_CLAIM: begin
        we           = 1'b1;
        wdata        = hold;
        wdata.status = rrqs_pkg::ST_RUN;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
    rvld  <= vld[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_valid  <= 1'b0;
      last_valid <= 1'b0;
      tick       <= '0;
      done       <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            ev     <= head;
            disp   <= 1'b0;
            endreq <= 1'b0;
            fin    <= 1'b0;
            fwait  <= '0;
            fturn  <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          ptr <= '0;
          cnt <= '0;
          unique case (ev.op)
            rrqs_pkg::OP_CREATE: begin
              if (ev.inr && cur_valid && cur == ev.slot) begin
                cur_valid <= 1'b0;
              end
              state <= S_OUT;
            end
            rrqs_pkg::OP_TICK: begin
              if (tick != rrqs_pkg::TMAX) begin
                tick <= tick + 1'b1;
              end
              if (cfg.n == '0) begin
                state <= cur_valid ? S_RUN_RD : S_DSTART;
              end else begin
                state <= S_WALK_RD;
              end
            end
            rrqs_pkg::OP_IO:    state <= cur_valid ? S_RUN_RD : S_OUT;
            rrqs_pkg::OP_EXIT:  state <= ev.inr ? S_EXIT_RD : S_OUT;
            rrqs_pkg::OP_START: state <= S_DSTART;
            default:            state <= S_OUT;
          endcase
        end
        S_WALK_RD: state <= S_WALK_WR;
        S_WALK_WR: begin
          ptr <= ptr + 1'b1;
          cnt <= cnt + 1'b1;
          if (last_step) begin
            state <= cur_valid ? S_RUN_RD : S_DSTART;
          end else begin
            state <= S_WALK_RD;
          end
        end
        S_RUN_RD: state <= S_RUN_WR;
        S_RUN_WR: begin
          if (st != rrqs_pkg::ST_RUN) begin
            state <= S_OUT;
          end else if (ev.op == rrqs_pkg::OP_IO) begin
            state <= S_DSTART;
          end else if (b_dec == '0) begin
            if (ev.eni) begin
              endreq <= 1'b1;
              state  <= S_OUT;
            end else begin
              state <= S_DSTART;
            end
          end else if (q_dec == '0) begin
            state <= S_DSTART;
          end else begin
            state <= S_OUT;
          end
        end
        S_EXIT_RD: state <= S_EXIT_WR;
        S_EXIT_WR: begin
          if (st != rrqs_pkg::ST_DONE) begin
            fin   <= 1'b1;
            fwait <= rd.rt;
            fturn <= tick - rd.arr;
            if (done != rrqs_pkg::DONE_MAX) begin
              done <= done + 1'b1;
            end
            if (cur_valid && cur == ev.slot) begin
              cur_valid <= 1'b0;
              state     <= S_DSTART;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_OUT;
          end
        end
        S_DSTART: begin
          found <= 1'b0;
          cnt   <= '0;
          start <= last_valid ? rrqs_pkg::CNT_W'(last) + rrqs_pkg::CNT_W'(1) : '0;
          if (cfg.n == '0) begin
            state <= cur_valid ? S_CUR_RD : S_OUT;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (start >= cfg.n) begin
            start <= start - cfg.n;
          end else begin
            ptr   <= start[rrqs_pkg::SLOT_W-1:0];
            state <= S_FIND_RD;
          end
        end
        S_FIND_RD: state <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (st == rrqs_pkg::ST_READY) begin
            hold  <= rd;
            found <= 1'b1;
            state <= cur_valid ? S_CUR_RD : S_CLAIM;
          end else begin
            ptr <= ptr_wrap;
            cnt <= cnt + 1'b1;
            if (last_step) begin
              state <= cur_valid ? S_CUR_RD : S_OUT;
            end else begin
              state <= S_FIND_RD;
            end
          end
        end
        S_CUR_RD: state <= S_CUR_CHK;
        S_CUR_CHK: begin
          if (found) begin
            state <= S_CLAIM;
          end else begin
            if (st != rrqs_pkg::ST_RUN) begin
              cur_valid <= 1'b0;
            end
            state <= S_OUT;
          end
        end
        S_CLAIM: begin
          cur        <= ptr;
          cur_valid  <= 1'b1;
          last       <= ptr;
          last_valid <= 1'b1;
          disp       <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      res_q.running_valid       <= cur_valid;
      res_q.running_slot        <= cur_valid ? rrqs_pkg::SLOT_FW'(cur) : '0;
      res_q.dispatched          <= disp;
      res_q.end_request         <= endreq;
      res_q.finished_valid      <= fin;
      res_q.finished_wait       <= fwait;
      res_q.finished_turnaround <= fturn;
      res_q.finished_count      <= done;
      res_q.all_done            <= done == rrqs_pkg::DONE_W'(cfg.pc);
      res_q.now                 <= tick;
    end
  end

  assign res.valid               = res_valid;
  assign res.running_valid       = res_q.running_valid;
  assign res.running_slot        = res_q.running_slot;
  assign res.dispatched          = res_q.dispatched;
  assign res.end_request         = res_q.end_request;
  assign res.finished_valid      = res_q.finished_valid;
  assign res.finished_wait       = res_q.finished_wait;
  assign res.finished_turnaround = res_q.finished_turnaround;
  assign res.finished_count      = res_q.finished_count;
  assign res.all_done            = res_q.all_done;
  assign res.now                 = res_q.now;

  `RRQS_ASSERT_IMPLY(a_idle_slot_zero, clk, rst, res_valid && !res_q.running_valid, res_q.running_slot == '0)
  `RRQS_ASSERT_IMPLY(a_fin_stats_zero, clk, rst, res_valid && !res_q.finished_valid, res_q.finished_wait == '0 && res_q.finished_turnaround == '0)
  `RRQS_ASSERT_IMPLY(a_claim_found, clk, rst, state == S_CLAIM, found)
  `RRQS_ASSERT_NEXT(a_pop_exec, clk, rst, pop, state == S_EXEC)

endmodule

[rtl/core/round_robin_quantum_scheduler_core.sv]
// The executor handles events one at a time; each slot visit is a read-modify-write
//   on the slot table, which has one read port and one write port.
// Reset: all slots done, no task running, tick and completion counts zero.
// ---------------------------------------------------------------------------
// round_robin_quantum_scheduler_core
// Round robin task scheduler with a time quantum over a table of task slots.
// ---------------------------------------------------------------------------
module round_robin_quantum_scheduler_core (
  input  logic       clk,
  input  logic       rst,
  rrqs_evt_if.sink   evt,
  rrqs_res_if.source res,
  rrqs_cfg_if.sink   cfg
);

  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  rrqs_pkg::event_t push_data;
  rrqs_pkg::event_t head;
  rrqs_pkg::cfg_t   cfg_q;

  rrqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_data (push_data),
    .cfg_o     (cfg_q)
  );

  rrqs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  rrqs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .empty (empty),
    .head  (head),
    .pop   (pop),
    .cfg   (cfg_q),
    .res   (res)
  );

endmodule
